@@ rtl/jog_pkg.sv @@
package jog_pkg;

    // Field widths
    localparam int SAMPLE_BITS = 10;
    localparam int AXES        = 3;
    localparam int BUTTONS     = 6;
    localparam int MOVE_BITS   = 3;
    localparam int DELAY_BITS  = 10;
    localparam int FAULT_BITS  = 2;
    localparam int MEAN_BITS   = 24;
    localparam int LIM_BITS    = 22;
    localparam int TOL_BITS    = 8;
    localparam int OFFS_BITS   = 16;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 22;
    localparam int STUCK_BITS  = 4;
    localparam int RAMP_BITS   = 11;

    // Position counters, and a width that holds differences and limits without overflow
    localparam int POS_BITS = 24;
    localparam int CMP_BITS = ((POS_BITS > LIM_BITS) ? POS_BITS : LIM_BITS) + 2;
    localparam int EXT_BITS = 32;

    // Switch window arithmetic runs signed, with room below zero
    localparam int SW_BITS = SAMPLE_BITS + 2;

    localparam int CLOSED_LEVEL   = 671;
    localparam int RAMP_THRESHOLD = 400;
    localparam int STUCK_LIMIT    = 10;
    localparam int DELAY_FLOOR    = 40;

    // Register reset values
    localparam logic [LIM_BITS-1:0]    HEIGHT_CAP_RST     = LIM_BITS'(90000);
    localparam logic [LIM_BITS-1:0]    TILT_SPAN_RST      = LIM_BITS'(40000);
    localparam logic [SAMPLE_BITS-1:0] OPEN_CENTER_RST    = SAMPLE_BITS'(318);
    localparam logic [TOL_BITS-1:0]    OPEN_TOLERANCE_RST = TOL_BITS'(23);
    localparam logic [SAMPLE_BITS-1:0] SHORT_LEVEL_RST    = SAMPLE_BITS'(286);
    localparam logic [SAMPLE_BITS-1:0] BROKEN_LEVEL_RST   = SAMPLE_BITS'(704);
    localparam logic [DELAY_BITS-1:0]  START_DELAY_RST    = DELAY_BITS'(500);
    localparam logic [OFFS_BITS-1:0]   FOCUS_OFFSET_RST   = OFFS_BITS'(12800);

    typedef logic signed [POS_BITS-1:0] pos_t;
    typedef logic signed [CMP_BITS-1:0] cmp_t;
    typedef logic signed [SW_BITS-1:0]  swv_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_HEIGHT_CAP     = 3'd0,
        CFG_TILT_SPAN      = 3'd1,
        CFG_OPEN_CENTER    = 3'd2,
        CFG_OPEN_TOLERANCE = 3'd3,
        CFG_SHORT_LEVEL    = 3'd4,
        CFG_BROKEN_LEVEL   = 3'd5,
        CFG_START_DELAY    = 3'd6,
        CFG_FOCUS_OFFSET   = 3'd7
    } cfg_idx_t;

    typedef enum logic [MOVE_BITS-1:0] {
        MV_NONE      = 3'd0,
        MV_UP        = 3'd1,
        MV_DOWN      = 3'd2,
        MV_TILT_DOWN = 3'd3,
        MV_TILT_UP   = 3'd4,
        MV_LEVEL     = 3'd5
    } move_t;

    typedef enum logic [FAULT_BITS-1:0] {
        FLT_NONE   = 2'd0,
        FLT_SHORT  = 2'd1,
        FLT_BROKEN = 2'd2,
        FLT_STUCK  = 2'd3
    } fault_t;

    // Button bit positions
    localparam int BTN_UP        = 0;
    localparam int BTN_DOWN      = 1;
    localparam int BTN_TILT_UP   = 2;
    localparam int BTN_TILT_DOWN = 3;
    localparam int BTN_LEVEL     = 4;

    typedef struct packed {
        logic [LIM_BITS-1:0]    height_cap;
        logic [LIM_BITS-1:0]    tilt_span;
        logic [SAMPLE_BITS-1:0] open_center;
        logic [TOL_BITS-1:0]    open_tolerance;
        logic [SAMPLE_BITS-1:0] short_level;
        logic [SAMPLE_BITS-1:0] broken_level;
        logic [DELAY_BITS-1:0]  start_delay;
        logic [OFFS_BITS-1:0]   focus_offset;
    } cfg_t;

    typedef struct packed {
        logic   clear;
        fault_t fault;
    } sw_t;

    typedef struct packed {
        logic [AXES-1:0]       step_pulse;
        logic [AXES-1:0]       step_dir_up;
        move_t                 move_kind;
        logic [DELAY_BITS-1:0] next_delay;
        logic                  switch_hit;
        fault_t                fault_code;
        logic                  many_buttons;
        logic                  report_now;
        logic [MEAN_BITS-1:0]  mean_position;
    } res_t;

endpackage

@@ rtl/jog_cfg.sv @@
module jog_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [jog_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [jog_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    output jog_pkg::cfg_t                       cfg
);
    import jog_pkg::*;

    cfg_t cfg_reg;

    // Write one register per enabled cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.height_cap     <= HEIGHT_CAP_RST;
            cfg_reg.tilt_span      <= TILT_SPAN_RST;
            cfg_reg.open_center    <= OPEN_CENTER_RST;
            cfg_reg.open_tolerance <= OPEN_TOLERANCE_RST;
            cfg_reg.short_level    <= SHORT_LEVEL_RST;
            cfg_reg.broken_level   <= BROKEN_LEVEL_RST;
            cfg_reg.start_delay    <= START_DELAY_RST;
            cfg_reg.focus_offset   <= FOCUS_OFFSET_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_HEIGHT_CAP:     cfg_reg.height_cap     <= cfg_data[LIM_BITS-1:0];
                CFG_TILT_SPAN:      cfg_reg.tilt_span      <= cfg_data[LIM_BITS-1:0];
                CFG_OPEN_CENTER:    cfg_reg.open_center    <= cfg_data[SAMPLE_BITS-1:0];
                CFG_OPEN_TOLERANCE: cfg_reg.open_tolerance <= cfg_data[TOL_BITS-1:0];
                CFG_SHORT_LEVEL:    cfg_reg.short_level    <= cfg_data[SAMPLE_BITS-1:0];
                CFG_BROKEN_LEVEL:   cfg_reg.broken_level   <= cfg_data[SAMPLE_BITS-1:0];
                CFG_START_DELAY:    cfg_reg.start_delay    <= cfg_data[DELAY_BITS-1:0];
                CFG_FOCUS_OFFSET:   cfg_reg.focus_offset   <= cfg_data[OFFS_BITS-1:0];
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/jog_switch.sv @@
module jog_switch (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              advance,
    input  logic [jog_pkg::SAMPLE_BITS-1:0]   sample,
    input  jog_pkg::cfg_t                     cfg,
    output jog_pkg::sw_t                      sw
);
    import jog_pkg::*;

    logic [STUCK_BITS-1:0] stuck_reg;
    logic [STUCK_BITS-1:0] stuck_next;
    swv_t                  s;
    swv_t                  win_hi;
    swv_t                  win_lo;
    swv_t                  mid_hi;
    logic                  clear;
    logic                  mid;
    fault_t                fault;

    // Window bounds, signed so the low bound may fall below zero
    assign s      = $signed({2'b00, sample});
    assign win_hi = $signed({2'b00, cfg.open_center}) + $signed({4'b0000, cfg.open_tolerance});
    assign win_lo = $signed({2'b00, cfg.open_center}) - $signed({4'b0000, cfg.open_tolerance});
    assign mid_hi = swv_t'(CLOSED_LEVEL) - $signed({4'b0000, cfg.open_tolerance});
    assign clear  = (s <= win_hi) && (s >= win_lo);
    assign mid    = (s > win_hi) && (s < mid_hi);

    // Classify the sample and count mid-state hits
    always_comb
    begin
        fault      = FLT_NONE;
        stuck_next = stuck_reg;
        if (clear)
        begin
            stuck_next = '0;
        end
        else if (s < $signed({2'b00, cfg.short_level}))
        begin
            fault = FLT_SHORT;
        end
        else if (s > $signed({2'b00, cfg.broken_level}))
        begin
            fault = FLT_BROKEN;
        end
        else if (mid)
        begin
            if (stuck_reg > STUCK_BITS'(STUCK_LIMIT))
                fault = FLT_STUCK;
            else
                stuck_next = stuck_reg + STUCK_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stuck_reg <= '0;
        else if (advance)
            stuck_reg <= stuck_next;
    end

    assign sw.clear = clear;
    assign sw.fault = fault;

endmodule

@@ rtl/jog_motion.sv @@
module jog_motion (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           advance,
    input  logic [jog_pkg::AXES-1:0]       endstop_bits,
    input  logic [jog_pkg::BUTTONS-1:0]    button_bits,
    input  jog_pkg::cfg_t                  cfg,
    input  jog_pkg::sw_t                   sw,
    output jog_pkg::res_t                  res
);
    import jog_pkg::*;

    localparam pos_t POS_MAX = pos_t'({1'b0, {(POS_BITS-1){1'b1}}});
    localparam pos_t POS_MIN = ~POS_MAX;

    // Position 0 is the mean counter, 1..3 the axes
    pos_t                  pos_reg [AXES+1];
    pos_t                  pos_next [AXES+1];
    pos_t                  focus_reg;
    pos_t                  focus_next;
    logic [RAMP_BITS-1:0]  ramp_reg;
    logic [RAMP_BITS-1:0]  ramp_next;
    logic [DELAY_BITS-1:0] delay_reg;
    logic [DELAY_BITS-1:0] delay_next;
    move_t                 prev_reg;
    logic                  single_reg;

    logic [2:0]            count;
    logic                  single;
    logic                  stopped;
    logic                  height_hit;
    cmp_t                  p0, p1, p2, p3;
    cmp_t                  height, tilt;
    logic                  focus_go;
    logic [AXES-1:0]       step_en;
    logic [AXES-1:0]       step_up;
    logic                  mean_en;
    logic                  mean_up;
    move_t                 move;
    logic [AXES-1:0]       pulse;
    logic [DELAY_BITS-1:0] delay_cut;
    logic [RAMP_BITS-1:0]  ramp_cut;
    logic signed [EXT_BITS-1:0] mean_ext;

    function automatic pos_t sat_step(input pos_t v, input logic up);
        pos_t r;
        r = v;
        if (up && (v != POS_MAX))
            r = v + pos_t'(1);
        else if (!up && (v != POS_MIN))
            r = v - pos_t'(1);
        return r;
    endfunction

    // The focus mark picks up the mean position on any switch hit
    assign focus_next = sw.clear ? focus_reg : pos_reg[0];

    assign count   = 3'($countones(button_bits));
    assign single  = (count == 3'd1);
    assign stopped = |endstop_bits;

    assign p0     = cmp_t'(pos_reg[0]);
    assign p1     = cmp_t'(pos_reg[1]);
    assign p2     = cmp_t'(pos_reg[2]);
    assign p3     = cmp_t'(pos_reg[3]);
    assign height = cmp_t'(cfg.height_cap);
    assign tilt   = cmp_t'(cfg.tilt_span);

    assign height_hit = (p1 > height) || (p2 > height) || (p3 > height);
    assign focus_go   = p0 > (cmp_t'(focus_next) - cmp_t'(cfg.focus_offset));

    // Pick the movement for the single pressed button
    always_comb
    begin
        step_en = '0;
        step_up = '0;
        mean_en = 1'b0;
        mean_up = 1'b0;
        move    = MV_NONE;
        if (single)
        begin
            priority if (button_bits[BTN_DOWN])
            begin
                if (!stopped)
                begin
                    step_en = 3'b111;
                    mean_en = 1'b1;
                    move    = MV_DOWN;
                end
            end
            else if (button_bits[BTN_UP])
            begin
                if (!height_hit && sw.clear)
                begin
                    step_en = 3'b111;
                    step_up = 3'b111;
                    mean_en = 1'b1;
                    mean_up = 1'b1;
                    move    = MV_UP;
                end
            end
            else if (button_bits[BTN_TILT_UP])
            begin
                if (!stopped && !height_hit && ((p3 - p1) < tilt) && sw.clear)
                begin
                    step_en = 3'b101;
                    step_up = 3'b100;
                    move    = MV_TILT_UP;
                end
            end
            else if (button_bits[BTN_TILT_DOWN])
            begin
                if (!stopped && !height_hit && ((p1 - p3) < tilt) && sw.clear)
                begin
                    step_en = 3'b101;
                    step_up = 3'b001;
                    move    = MV_TILT_DOWN;
                end
            end
            else if (button_bits[BTN_LEVEL])
            begin
                if (!stopped && sw.clear)
                begin
                    if (p1 > p3 + cmp_t'(1))
                    begin
                        step_en = 3'b101;
                        step_up = 3'b100;
                        move    = MV_LEVEL;
                    end
                    else if (p1 + cmp_t'(1) < p3)
                    begin
                        step_en = 3'b101;
                        step_up = 3'b001;
                        move    = MV_LEVEL;
                    end
                end
            end
            else
            begin
                if (focus_go)
                begin
                    step_en = 3'b111;
                    mean_en = 1'b1;
                    move    = MV_DOWN;
                end
            end
        end
    end

    // Refuse a downward step at an endstop
    assign pulse = step_en & (step_up | ~endstop_bits);

    // Update the position counters with saturation
    always_comb
    begin
        pos_next[0] = mean_en ? sat_step(pos_reg[0], mean_up) : pos_reg[0];
        for (int k = 1; k <= AXES; k++)
        begin
            pos_next[k] = pulse[k-1] ? sat_step(pos_reg[k], step_up[k-1]) : pos_reg[k];
        end
    end

    // Ramp the step delay down while the same movement continues
    always_comb
    begin
        delay_cut  = delay_reg;
        ramp_cut   = ramp_reg;
        delay_next = cfg.start_delay;
        ramp_next  = '0;
        if ((move == prev_reg) && (move != MV_NONE))
        begin
            if (ramp_reg > RAMP_BITS'(RAMP_THRESHOLD))
            begin
                delay_cut = (delay_reg > DELAY_BITS'(DELAY_FLOOR + 1))
                          ? delay_reg - DELAY_BITS'(1) : DELAY_BITS'(DELAY_FLOOR);
                ramp_cut  = '0;
            end
            delay_next = delay_cut;
            ramp_next  = ramp_cut + RAMP_BITS'(delay_cut);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= AXES; k++)
                pos_reg[k] <= '0;
            focus_reg  <= '0;
            ramp_reg   <= '0;
            delay_reg  <= START_DELAY_RST;
            prev_reg   <= MV_NONE;
            single_reg <= 1'b0;
        end
        else if (advance)
        begin
            for (int k = 0; k <= AXES; k++)
                pos_reg[k] <= pos_next[k];
            focus_reg  <= focus_next;
            ramp_reg   <= ramp_next;
            delay_reg  <= delay_next;
            prev_reg   <= move;
            single_reg <= single;
        end
    end

    assign mean_ext = EXT_BITS'(pos_next[0]);

    assign res.step_pulse    = pulse;
    assign res.step_dir_up   = pulse & step_up;
    assign res.move_kind     = move;
    assign res.next_delay    = delay_next;
    assign res.switch_hit    = ~sw.clear;
    assign res.fault_code    = sw.fault;
    assign res.many_buttons  = (count > 3'd1);
    assign res.report_now    = single_reg & ~single;
    assign res.mean_position = mean_ext[MEAN_BITS-1:0];

endmodule

@@ rtl/three_axis_jog_controller.sv @@
// A request accepted into the input register passes through the period logic into the result
// register once that register has room, and is held there until taken.
// Throughput: one request per cycle; the period update is combinational logic
// between the input register and the result register, and state updates with it.
// Input stalls only while both registers are full and the result is stalled.
// Reset (async, active low) clears positions, counters and valids and loads the
// default register values; no clearing pass is needed.
module three_axis_jog_controller (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [jog_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [jog_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [jog_pkg::SAMPLE_BITS-1:0]       switch_sample,
    input  logic [jog_pkg::AXES-1:0]              endstop_bits,
    input  logic [jog_pkg::BUTTONS-1:0]           button_bits,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [jog_pkg::AXES-1:0]              step_pulse,
    output logic [jog_pkg::AXES-1:0]              step_dir_up,
    output logic [jog_pkg::MOVE_BITS-1:0]         move_kind,
    output logic [jog_pkg::DELAY_BITS-1:0]        next_delay,
    output logic                                  switch_hit,
    output logic [jog_pkg::FAULT_BITS-1:0]        fault_code,
    output logic                                  many_buttons,
    output logic                                  report_now,
    output logic signed [jog_pkg::MEAN_BITS-1:0]  mean_position
);
    import jog_pkg::*;

    logic                   in_valid_reg;
    logic                   in_valid_next;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [AXES-1:0]        endstop_reg;
    logic [BUTTONS-1:0]     button_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    res_t                   res_reg;

    cfg_t                   cfg;
    sw_t                    sw;
    res_t                   res;
    logic                   out_free;
    logic                   advance;
    logic                   in_take;

    // Handshake: the input register moves on whenever the result register has room
    assign out_free = ~out_valid_reg | ~out_stall;
    assign advance  = in_valid_reg & out_free;
    assign in_stall = in_valid_reg & ~out_free;
    assign in_take  = in_valid & ~in_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the request
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            sample_reg  <= switch_sample;
            endstop_reg <= endstop_bits;
            button_reg  <= button_bits;
        end
    end

    // Hold the result until taken
    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res;
    end

    jog_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    jog_switch u_switch (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .sample  (sample_reg),
        .cfg     (cfg),
        .sw      (sw)
    );

    jog_motion u_motion (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .endstop_bits (endstop_reg),
        .button_bits  (button_reg),
        .cfg          (cfg),
        .sw           (sw),
        .res          (res)
    );

    assign out_valid     = out_valid_reg;
    assign step_pulse    = res_reg.step_pulse;
    assign step_dir_up   = res_reg.step_dir_up;
    assign move_kind     = res_reg.move_kind;
    assign next_delay    = res_reg.next_delay;
    assign switch_hit    = res_reg.switch_hit;
    assign fault_code    = res_reg.fault_code;
    assign many_buttons  = res_reg.many_buttons;
    assign report_now    = res_reg.report_now;
    assign mean_position = $signed(res_reg.mean_position);

endmodule

@@ rtl/jog_checker.sv @@
module jog_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  out_valid,
    input logic                                  out_stall,
    input logic [jog_pkg::AXES-1:0]              step_pulse,
    input logic [jog_pkg::AXES-1:0]              step_dir_up,
    input logic [jog_pkg::MOVE_BITS-1:0]         move_kind,
    input logic [jog_pkg::DELAY_BITS-1:0]        next_delay,
    input logic                                  switch_hit,
    input logic [jog_pkg::FAULT_BITS-1:0]        fault_code,
    input logic                                  many_buttons,
    input logic signed [jog_pkg::MEAN_BITS-1:0]  mean_position
);
    import jog_pkg::*;

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(step_pulse) && $stable(move_kind)
            && $stable(next_delay) && $stable(mean_position))
        else $error("result changed while stalled");

    // An idle axis shows no upward direction
    a_dir_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (step_dir_up & ~step_pulse) == '0)
        else $error("direction set on idle axis");

    // No movement means no step
    a_none_still: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (move_kind == MV_NONE) |-> step_pulse == '0)
        else $error("step without movement");

    // A clear switch reports no fault
    a_clear_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !switch_hit |-> fault_code == FLT_NONE)
        else $error("fault on clear switch");

    // Several buttons give no movement
    a_many_still: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && many_buttons |-> move_kind == MV_NONE)
        else $error("movement with several buttons");

endmodule

bind three_axis_jog_controller jog_checker u_jog_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .step_pulse    (step_pulse),
    .step_dir_up   (step_dir_up),
    .move_kind     (move_kind),
    .next_delay    (next_delay),
    .switch_hit    (switch_hit),
    .fault_code    (fault_code),
    .many_buttons  (many_buttons),
    .mean_position (mean_position)
);

@@ tb/tb_top.sv @@
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import jog_pkg::*;

    localparam int BTN_FOCUS = BTN_LEVEL + 1;
    localparam int QUIET_LIMIT = 2000;
    localparam int PHASES = 5;
    localparam longint POS_TOP = (longint'(1) << (POS_BITS - 1)) - 1;
    localparam longint POS_BOTTOM = -POS_TOP - 1;

    typedef struct {
        logic [SAMPLE_BITS-1:0] sample;
        logic [AXES-1:0]        stops;
        logic [BUTTONS-1:0]     buttons;
    } jog_request_t;

    // Block ports
    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        cfg_we = 1'b0;
    cfg_idx_t                    cfg_index = CFG_HEIGHT_CAP;
    logic [CFG_DATA_BITS-1:0]    cfg_data = '0;
    logic                        in_valid = 1'b0;
    logic                        in_stall;
    logic [SAMPLE_BITS-1:0]      switch_sample = '0;
    logic [AXES-1:0]             endstop_bits = '0;
    logic [BUTTONS-1:0]          button_bits = '0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic [AXES-1:0]             step_pulse;
    logic [AXES-1:0]             step_dir_up;
    logic [MOVE_BITS-1:0]        move_kind;
    logic [DELAY_BITS-1:0]       next_delay;
    logic                        switch_hit;
    logic [FAULT_BITS-1:0]       fault_code;
    logic                        many_buttons;
    logic                        report_now;
    logic signed [MEAN_BITS-1:0] mean_position;

    // Controller copy: registers and period state
    cfg_t                  settings;
    pos_t                  axis_pos [4];
    pos_t                  focus_mark;
    logic [STUCK_BITS-1:0] stuck_cnt;
    logic [RAMP_BITS-1:0]  ramp_acc;
    logic [DELAY_BITS-1:0] delay_now;
    move_t                 last_move;
    logic                  held_before;

    jog_request_t pending_requests [$];
    res_t         period_results [$];
    jog_request_t next_req;
    int           queued = 0;
    int           mismatches = 0;
    int           in_rate = 0;
    int           out_rate = 0;
    int           in_gap = 0;
    int           out_gap = 0;
    int           quiet_cycles = 0;

    three_axis_jog_controller dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Clear window bounds, signed so they may fall below zero
    function automatic void window(output int lo, output int hi);
        int oc;
        int ot;
        oc = settings.open_center;
        ot = settings.open_tolerance;
        lo = oc - ot;
        hi = oc + ot;
    endfunction

    function automatic pos_t nudge(pos_t p, bit up);
        longint v;
        v = p;
        v = v + (up ? 1 : -1);
        if (v > POS_TOP)
            v = POS_TOP;
        if (v < POS_BOTTOM)
            v = POS_BOTTOM;
        return pos_t'(v);
    endfunction

    // Step one axis; refuse a downward step at its endstop
    function automatic void axis_move(int ax, bit up, logic [AXES-1:0] stops,
                                      inout logic [AXES-1:0] pulse,
                                      inout logic [AXES-1:0] dir);
        if (!up && stops[ax-1])
            return;
        axis_pos[ax] = nudge(axis_pos[ax], up);
        pulse[ax-1] = 1'b1;
        dir[ax-1] = up;
    endfunction

    function automatic void move_all(bit up, logic [AXES-1:0] stops,
                                     inout logic [AXES-1:0] pulse,
                                     inout logic [AXES-1:0] dir);
        for (int k = 1; k <= AXES; k++)
            axis_move(k, up, stops, pulse, dir);
        axis_pos[0] = nudge(axis_pos[0], up);
    endfunction

    function automatic bit above_height();
        longint lim;
        lim = settings.height_cap;
        return longint'(axis_pos[1]) > lim || longint'(axis_pos[2]) > lim ||
               longint'(axis_pos[3]) > lim;
    endfunction

    // One control period: classify the switch, jog, ramp the delay
    function automatic res_t step_period(logic [SAMPLE_BITS-1:0] sample,
                                         logic [AXES-1:0] stops,
                                         logic [BUTTONS-1:0] buttons);
        res_t            r;
        int              s;
        int              lo;
        int              hi;
        int              ot;
        int              presses;
        bit              clear;
        bit              stopped;
        bit              high;
        longint          p1;
        longint          p3;
        longint          tilt;
        longint          mark;
        longint          offs;
        logic [AXES-1:0] pulse;
        logic [AXES-1:0] dir;
        move_t           mv;
        fault_t          flt;
        window(lo, hi);
        s = sample;
        ot = settings.open_tolerance;
        clear = (s <= hi) && (s >= lo);
        flt = FLT_NONE;
        pulse = '0;
        dir = '0;
        mv = MV_NONE;

        // Record the hit position and classify the fault
        if (!clear)
        begin
            focus_mark = axis_pos[0];
            if (s < int'(settings.short_level))
                flt = FLT_SHORT;
            else if (s > int'(settings.broken_level))
                flt = FLT_BROKEN;
            else if (s > hi && s < CLOSED_LEVEL - ot)
            begin
                if (stuck_cnt > STUCK_LIMIT)
                    flt = FLT_STUCK;
                else
                    stuck_cnt = stuck_cnt + 1'b1;
            end
        end
        else
            stuck_cnt = '0;

        presses = $countones(buttons);
        r.report_now = held_before && presses != 1;
        held_before = (presses == 1);

        // Jog only on a single press
        if (presses == 1)
        begin
            stopped = (stops != '0);
            high = above_height();
            p1 = axis_pos[1];
            p3 = axis_pos[3];
            tilt = settings.tilt_span;
            if (buttons[BTN_DOWN])
            begin
                if (!stopped)
                begin
                    move_all(1'b0, stops, pulse, dir);
                    mv = MV_DOWN;
                end
            end
            else if (buttons[BTN_UP])
            begin
                if (!high && clear)
                begin
                    move_all(1'b1, stops, pulse, dir);
                    mv = MV_UP;
                end
            end
            else if (buttons[BTN_TILT_UP])
            begin
                if (!stopped && !high && p3 - p1 < tilt && clear)
                begin
                    axis_move(3, 1'b1, stops, pulse, dir);
                    axis_move(1, 1'b0, stops, pulse, dir);
                    mv = MV_TILT_UP;
                end
            end
            else if (buttons[BTN_TILT_DOWN])
            begin
                if (!stopped && !high && p1 - p3 < tilt && clear)
                begin
                    axis_move(3, 1'b0, stops, pulse, dir);
                    axis_move(1, 1'b1, stops, pulse, dir);
                    mv = MV_TILT_DOWN;
                end
            end
            else if (buttons[BTN_LEVEL])
            begin
                if (!stopped && clear)
                begin
                    if (p1 > p3 + 1)
                    begin
                        axis_move(1, 1'b0, stops, pulse, dir);
                        axis_move(3, 1'b1, stops, pulse, dir);
                        mv = MV_LEVEL;
                    end
                    else if (p1 + 1 < p3)
                    begin
                        axis_move(3, 1'b0, stops, pulse, dir);
                        axis_move(1, 1'b1, stops, pulse, dir);
                        mv = MV_LEVEL;
                    end
                end
            end
            else
            begin
                // Focus: go down toward the mark, even past a blocked axis
                mark = focus_mark;
                offs = settings.focus_offset;
                if (longint'(axis_pos[0]) > mark - offs)
                begin
                    move_all(1'b0, stops, pulse, dir);
                    mv = MV_DOWN;
                end
            end
        end

        // Ramp the delay down while the same movement continues
        if (mv == last_move && mv != MV_NONE)
        begin
            if (ramp_acc > RAMP_THRESHOLD)
            begin
                delay_now = (delay_now > DELAY_FLOOR + 1) ? delay_now - 1'b1
                                                          : DELAY_BITS'(DELAY_FLOOR);
                ramp_acc = '0;
            end
            ramp_acc = ramp_acc + delay_now;
        end
        else
        begin
            delay_now = settings.start_delay;
            ramp_acc = '0;
        end
        last_move = mv;

        r.step_pulse = pulse;
        r.step_dir_up = dir;
        r.move_kind = mv;
        r.next_delay = delay_now;
        r.switch_hit = !clear;
        r.fault_code = flt;
        r.many_buttons = presses > 1;
        r.mean_position = axis_pos[0];
        return r;
    endfunction

    // Stimulus helpers
    function automatic logic [BUTTONS-1:0] press(int b);
        return BUTTONS'(1) << b;
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] pick_any();
        return SAMPLE_BITS'($urandom);
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] pick_clear();
        int lo;
        int hi;
        window(lo, hi);
        if (lo < 0)
            lo = 0;
        if (hi > 1023)
            hi = 1023;
        return SAMPLE_BITS'($urandom_range(hi, lo));
    endfunction

    // Hit between the clear window and the closed band
    function automatic logic [SAMPLE_BITS-1:0] pick_mid();
        int lo;
        int hi;
        int ot;
        window(lo, hi);
        ot = settings.open_tolerance;
        lo = hi + 1;
        if (lo < int'(settings.short_level))
            lo = settings.short_level;
        hi = CLOSED_LEVEL - ot - 1;
        if (hi > int'(settings.broken_level))
            hi = settings.broken_level;
        if (lo > hi || lo < 0)
            return pick_any();
        return SAMPLE_BITS'($urandom_range(hi, lo));
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        int r;
        r = $urandom_range(99);
        if (r < 80)
            return pick_clear();
        if (r < 90)
            return pick_mid();
        return pick_any();
    endfunction

    task automatic add_request(logic [SAMPLE_BITS-1:0] sample, logic [AXES-1:0] stops,
                               logic [BUTTONS-1:0] buttons);
        jog_request_t req;
        req.sample = sample;
        req.stops = stops;
        req.buttons = buttons;
        pending_requests.push_back(req);
        queued++;
    endtask

    // Hold one button for a run of periods, with an occasional stray press
    task automatic queue_jog_run();
        int                 btn;
        int                 len;
        logic [BUTTONS-1:0] buttons;
        logic [AXES-1:0]    stops;
        btn = $urandom_range(BUTTONS - 1);
        len = ($urandom_range(9) == 0) ? $urandom_range(120, 50) : $urandom_range(30, 1);
        repeat (len)
        begin
            buttons = ($urandom_range(19) == 0) ? BUTTONS'($urandom) : press(btn);
            stops = ($urandom_range(7) == 0) ? AXES'($urandom) : '0;
            add_request(pick_sample(), stops, buttons);
        end
    endtask

    task automatic queue_random(int n);
        int start;
        int pick;
        int len;
        start = queued;
        while (queued - start < n)
        begin
            pick = $urandom_range(99);
            if (pick < 72)
                queue_jog_run();
            else if (pick < 82)
            begin
                // Long mid-state stretch to trip the stuck fault
                len = $urandom_range(16, 6);
                repeat (len)
                    add_request(pick_mid(), '0,
                                ($urandom_range(3) == 0) ? BUTTONS'($urandom) : '0);
            end
            else
            begin
                len = $urandom_range(4, 1);
                repeat (len)
                    add_request(pick_any(), AXES'($urandom), BUTTONS'($urandom));
            end
        end
    endtask

    // Directed opening under reset register values
    task automatic queue_directed();
        add_request(10'd318, 3'd0, '0);
        add_request(10'd0, 3'd7, press(BTN_DOWN));
        add_request(10'd1023, 3'd0, '0);
        add_request(10'd660, 3'd0, '0);
        add_request(10'd300, 3'd0, press(BTN_UP));
        add_request(10'd336, 3'd0, press(BTN_UP));
        add_request(10'd318, 3'd0, press(BTN_DOWN));
        add_request(10'd318, 3'd0, press(BTN_DOWN));
        add_request(10'd318, 3'd0, press(BTN_TILT_UP));
        add_request(10'd318, 3'd0, press(BTN_TILT_UP));
        add_request(10'd318, 3'd0, press(BTN_TILT_DOWN));
        add_request(10'd318, 3'd0, press(BTN_LEVEL));
        add_request(10'd318, 3'd1, press(BTN_DOWN));
        // Focus past two endstops while the switch sits in the mid state
        add_request(10'd500, 3'd5, press(BTN_FOCUS));
        for (int i = 0; i < 11; i++)
            add_request(SAMPLE_BITS'($urandom_range(647, 342)), 3'd0,
                        (i % 2 == 1) ? press(BTN_UP) : '0);
        add_request(10'd318, 3'd0, press(BTN_FOCUS));
        add_request(10'd318, 3'd0, '1);
    endtask

    function automatic cfg_t phase_settings(int ph);
        cfg_t s;
        case (ph)
            1: s = '{22'd20, 22'd4, 10'd318, 8'd23, 10'd286, 10'd704, 10'd40, 16'd6};
            2: s = '{22'd0, 22'd0, 10'd0, 8'd255, 10'd0, 10'd1023, 10'd1000, 16'd0};
            3: s = '{22'h3FFFFF, 22'h3FFFFF, 10'd1023, 8'd0, 10'd1023, 10'd0, 10'd0,
                     16'hFFFF};
            4:
            begin
                s.height_cap = LIM_BITS'($urandom_range(60));
                s.tilt_span = LIM_BITS'($urandom_range(10));
                s.open_center = SAMPLE_BITS'($urandom_range(450, 200));
                s.open_tolerance = TOL_BITS'($urandom_range(60, 5));
                s.short_level = SAMPLE_BITS'($urandom_range(300, 100));
                s.broken_level = SAMPLE_BITS'($urandom_range(900, 600));
                s.start_delay = DELAY_BITS'($urandom_range(1023));
                s.focus_offset = OFFS_BITS'($urandom_range(40));
            end
            default: s = '{22'd30, 22'd8, 10'd512, 8'd40, 10'd400, 10'd650, 10'd1023, 16'd12};
        endcase
        return s;
    endfunction

    // Write every register; junk above a register's width must be dropped
    task automatic load_settings(cfg_t s);
        cfg_idx_t                 idx;
        logic [CFG_DATA_BITS-1:0] value;
        int                       w;
        for (int i = 0; i < (1 << CFG_IDX_BITS); i++)
        begin
            idx = cfg_idx_t'(i);
            value = '0;
            w = CFG_DATA_BITS;
            case (idx)
                CFG_HEIGHT_CAP:
                begin
                    value = CFG_DATA_BITS'(s.height_cap);
                    w = LIM_BITS;
                end
                CFG_TILT_SPAN:
                begin
                    value = CFG_DATA_BITS'(s.tilt_span);
                    w = LIM_BITS;
                end
                CFG_OPEN_CENTER:
                begin
                    value = CFG_DATA_BITS'(s.open_center);
                    w = SAMPLE_BITS;
                end
                CFG_OPEN_TOLERANCE:
                begin
                    value = CFG_DATA_BITS'(s.open_tolerance);
                    w = TOL_BITS;
                end
                CFG_SHORT_LEVEL:
                begin
                    value = CFG_DATA_BITS'(s.short_level);
                    w = SAMPLE_BITS;
                end
                CFG_BROKEN_LEVEL:
                begin
                    value = CFG_DATA_BITS'(s.broken_level);
                    w = SAMPLE_BITS;
                end
                CFG_START_DELAY:
                begin
                    value = CFG_DATA_BITS'(s.start_delay);
                    w = DELAY_BITS;
                end
                CFG_FOCUS_OFFSET:
                begin
                    value = CFG_DATA_BITS'(s.focus_offset);
                    w = OFFS_BITS;
                end
            endcase
            if ($urandom_range(1) == 1)
                value = value | (CFG_DATA_BITS'($urandom) << w);
            @(posedge clk);
            cfg_we <= 1'b1;
            cfg_index <= idx;
            cfg_data <= value;
        end
        @(posedge clk);
        cfg_we <= 1'b0;
        settings = s;
    endtask

    // Wait until every request is in and every result checked
    task automatic settle();
        do
            @(negedge clk);
        while (pending_requests.size() != 0 || in_valid || period_results.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic compare_field(string field, longint want, longint got);
        if (want != got)
        begin
            mismatches++;
            if (mismatches <= 40)
                $display("%0t %s: expected %0d, got %0d", $time, field, want, got);
        end
    endtask

    task automatic check_result();
        res_t want;
        if (period_results.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 40)
                $display("%0t result: expected none, got move %0d mean %0d",
                         $time, move_kind, mean_position);
        end
        else
        begin
            want = period_results.pop_front();
            compare_field("step_pulse", want.step_pulse, step_pulse);
            compare_field("step_dir_up", want.step_dir_up, step_dir_up);
            compare_field("move_kind", want.move_kind, move_kind);
            compare_field("next_delay", want.next_delay, next_delay);
            compare_field("switch_hit", want.switch_hit, switch_hit);
            compare_field("fault_code", want.fault_code, fault_code);
            compare_field("many_buttons", want.many_buttons, many_buttons);
            compare_field("report_now", want.report_now, report_now);
            compare_field("mean_position", $signed(want.mean_position), mean_position);
        end
    endtask

    // Request driver: predict on accept, then load the next request or idle
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                period_results.push_back(step_period(switch_sample, endstop_bits,
                                                     button_bits));
            if (!in_valid || !in_stall)
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_requests.size() > 0)
                begin
                    next_req = pending_requests.pop_front();
                    in_valid <= 1'b1;
                    switch_sample <= next_req.sample;
                    endstop_bits <= next_req.stops;
                    button_bits <= next_req.buttons;
                    if ($urandom_range(99) < in_rate)
                        in_gap = $urandom_range(8, 1);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Result monitor with random stall bursts
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                check_result();
            if (out_gap > 0)
                out_gap--;
            else if ($urandom_range(99) < out_rate)
                out_gap = $urandom_range(8, 1);
            out_stall <= (out_gap > 0);
        end
    end

    // Watchdog: abort when nothing moves on either side for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        settings = '{HEIGHT_CAP_RST, TILT_SPAN_RST, OPEN_CENTER_RST, OPEN_TOLERANCE_RST,
                     SHORT_LEVEL_RST, BROKEN_LEVEL_RST, START_DELAY_RST, FOCUS_OFFSET_RST};
        for (int k = 0; k < 4; k++)
            axis_pos[k] = '0;
        focus_mark = '0;
        stuck_cnt = '0;
        ramp_acc = '0;
        delay_now = START_DELAY_RST;
        last_move = MV_NONE;
        held_before = 1'b0;
        in_rate = 20;
        out_rate = 20;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Reset register values first
        @(negedge clk);
        queue_directed();
        queue_random(230);
        settle();

        // Then one setting per phase; the last one runs without idling
        for (int ph = 1; ph <= PHASES; ph++)
        begin
            load_settings(phase_settings(ph));
            case (ph)
                1: begin in_rate = 10; out_rate = 30; end
                2: begin in_rate = 30; out_rate = 10; end
                3: begin in_rate = 0;  out_rate = 25; end
                4: begin in_rate = 25; out_rate = 0;  end
                default: begin in_rate = 0; out_rate = 0; end
            endcase
            @(negedge clk);
            queue_random(285);
            settle();
        end

        repeat (6) @(posedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/jog_pkg.sv
rtl/jog_cfg.sv
rtl/jog_switch.sv
rtl/jog_motion.sv
rtl/three_axis_jog_controller.sv
rtl/jog_checker.sv
tb/tb_top.sv
